### design/ctlp_pkg.sv
// ----------------------------------------------------------------------------
// ctlp_pkg: shared types and constants for the CNF text literal parser
// Result kinds, error codes and the character codes the parser matches.
// ----------------------------------------------------------------------------
package ctlp_pkg;

    localparam int unsigned ValueWidth = 31;
    localparam int unsigned LitWidth   = 32;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_LITERAL = 2'd1,
        KIND_ERROR   = 2'd2,
        KIND_END     = 2'd3
    } result_kind_t;

    typedef enum logic [3:0] {
        ERR_EOF_HEADER_COMMENT = 4'd0,
        ERR_BAD_HEADER_TEXT    = 4'd1,
        ERR_HEADER_NUM_MISSING = 4'd2,
        ERR_HEADER_NUM_OVF     = 4'd3,
        ERR_NO_HEADER_NEWLINE  = 4'd4,
        ERR_EOF_COMMENT        = 4'd5,
        ERR_EXPECT_DIGIT_MINUS = 4'd6,
        ERR_BAD_DIGIT_MINUS    = 4'd7,
        ERR_LITERAL_OVF        = 4'd8,
        ERR_BAD_DELIMITER      = 4'd9,
        ERR_EXCEEDS_MAX_VAR    = 4'd10,
        ERR_MISSING_ZERO       = 4'd11
    } error_code_t;

    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [ValueWidth-1:0] VALUE_LIMIT = 31'h7FFF_FFFF;

endpackage

### design/cnf_text_literal_parser.sv
// ----------------------------------------------------------------------------
// cnf_text_literal_parser: byte-serial DIMACS CNF header and literal parser
// Each byte is held in the input register, then decoded into the result register;
// an output stall holds both. Throughput: one byte per cycle while the output
// is not stalled, set by the single decode and accumulate step.
// Reset clears the input and result valids, the parse phase, the header values
// and the clause flag; after an error or a clean end nothing more is produced.
// ----------------------------------------------------------------------------
module cnf_text_literal_parser
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          byte_value,
    input  logic                                end_of_input,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          result_kind,
    output logic signed [ctlp_pkg::LitWidth-1:0] literal,
    output logic [ctlp_pkg::ValueWidth-1:0]     max_variable,
    output logic [ctlp_pkg::ValueWidth-1:0]     clause_count,
    output logic [3:0]                          error_code
);

    typedef enum logic [4:0] {
        PH_START, PH_HCOMMENT, PH_P_SPACE, PH_C, PH_N, PH_F, PH_F_SPACE,
        PH_M_FIRST, PH_M_DIGITS, PH_N_FIRST, PH_N_DIGITS, PH_TRAIL, PH_CR,
        PH_BODY, PH_BCOMMENT, PH_MINUS, PH_LIT, PH_LCOMMENT, PH_DONE, PH_STOP
    } phase_t;

    // input register
    logic                               in_valid_reg;
    logic [7:0]                         byte_reg;
    logic                               eof_reg;

    // parser state
    phase_t                             phase_reg, phase_next;
    logic [ctlp_pkg::ValueWidth-1:0]    acc_reg, acc_next;
    logic                               neg_reg, neg_next;
    logic [ctlp_pkg::ValueWidth-1:0]    hmax_reg, hmax_next;
    logic [ctlp_pkg::ValueWidth-1:0]    hcl_reg, hcl_next;
    logic                               open_reg, open_next;

    // result register
    logic                               out_valid_reg;
    ctlp_pkg::result_kind_t             kind_reg, kind_next;
    logic [ctlp_pkg::LitWidth-1:0]      lit_reg, lit_next;
    logic [ctlp_pkg::ValueWidth-1:0]    max_reg;
    logic [ctlp_pkg::ValueWidth-1:0]    cl_reg;
    ctlp_pkg::error_code_t              code_reg, code_next;

    logic                               advance;
    logic                               fire;
    logic                               has_result;
    logic                               fail;
    ctlp_pkg::error_code_t              fail_code;
    logic                               emit;
    logic                               header_ok;

    logic                               is_digit;
    logic                               is_blank;
    logic [3:0]                         digit;
    logic [ctlp_pkg::ValueWidth+3:0]    acc_sum;
    logic                               acc_ovf;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    assign is_digit = (byte_reg >= ctlp_pkg::CH_ZERO) && (byte_reg <= ctlp_pkg::CH_NINE);
    assign is_blank = (byte_reg == ctlp_pkg::CH_SPACE) || (byte_reg == ctlp_pkg::CH_TAB)
                   || (byte_reg == ctlp_pkg::CH_CR) || (byte_reg == ctlp_pkg::CH_LF);
    assign digit    = byte_reg[3:0];

    // acc * 10 + digit, as two shifts and two adds
    assign acc_sum = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                   + {{(ctlp_pkg::ValueWidth){1'b0}}, digit};
    assign acc_ovf = (acc_sum[ctlp_pkg::ValueWidth+3:ctlp_pkg::ValueWidth] != 4'd0);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        hmax_next  = hmax_reg;
        hcl_next   = hcl_reg;
        open_next  = open_reg;
        fail       = 1'b0;
        fail_code  = ctlp_pkg::ERR_EOF_HEADER_COMMENT;
        emit       = 1'b0;
        header_ok  = 1'b0;
        has_result = 1'b0;
        kind_next  = ctlp_pkg::KIND_HEADER;
        lit_next   = '0;
        code_next  = ctlp_pkg::ERR_EOF_HEADER_COMMENT;

        case (phase_reg)
            PH_START:
            begin
                if (eof_reg)
                begin
                    fail = 1'b1; fail_code = ctlp_pkg::ERR_BAD_HEADER_TEXT;
                end
                else if (byte_reg == ctlp_pkg::CH_C)
                    phase_next = PH_HCOMMENT;
                else if (byte_reg == ctlp_pkg::CH_P)
                    phase_next = PH_P_SPACE;
                else
                begin
                    fail = 1'b1; fail_code = ctlp_pkg::ERR_BAD_HEADER_TEXT;
                end
            end
            PH_HCOMMENT:
            begin
                if (eof_reg)
                begin
                    fail = 1'b1; fail_code = ctlp_pkg::ERR_EOF_HEADER_COMMENT;
                end
                else if (byte_reg == ctlp_pkg::CH_LF)
                    phase_next = PH_START;
            end
            PH_P_SPACE, PH_F_SPACE:
            begin
                if (eof_reg || byte_reg != ctlp_pkg::CH_SPACE)
                begin
                    fail = 1'b1; fail_code = ctlp_pkg::ERR_BAD_HEADER_TEXT;
                end
                else
                    phase_next = (phase_reg == PH_P_SPACE) ? PH_C : PH_M_FIRST;
            end
            PH_C:
            begin
                if (eof_reg || byte_reg != ctlp_pkg::CH_C)
                begin
                    fail = 1'b1; fail_code = ctlp_pkg::ERR_BAD_HEADER_TEXT;
                end
                else
                    phase_next = PH_N;
            end
            PH_N:
            begin
                if (eof_reg || byte_reg != ctlp_pkg::CH_N)
                begin
                    fail = 1'b1; fail_code = ctlp_pkg::ERR_BAD_HEADER_TEXT;
                end
                else
                    phase_next = PH_F;
            end
            PH_F:
            begin
                if (eof_reg || byte_reg != ctlp_pkg::CH_F)
                begin
                    fail = 1'b1; fail_code = ctlp_pkg::ERR_BAD_HEADER_TEXT;
                end
                else
                    phase_next = PH_F_SPACE;
            end
            PH_M_FIRST, PH_N_FIRST:
            begin
                if (eof_reg || !is_digit)
                begin
                    fail = 1'b1; fail_code = ctlp_pkg::ERR_HEADER_NUM_MISSING;
                end
                else
                begin
                    acc_next   = {{(ctlp_pkg::ValueWidth-4){1'b0}}, digit};
                    phase_next = (phase_reg == PH_M_FIRST) ? PH_M_DIGITS : PH_N_DIGITS;
                end
            end
            PH_M_DIGITS:
            begin
                if (!eof_reg && is_digit)
                begin
                    if (acc_ovf)
                    begin
                        fail = 1'b1; fail_code = ctlp_pkg::ERR_HEADER_NUM_OVF;
                    end
                    else
                        acc_next = acc_sum[ctlp_pkg::ValueWidth-1:0];
                end
                else if (eof_reg || byte_reg != ctlp_pkg::CH_SPACE)
                begin
                    fail = 1'b1; fail_code = ctlp_pkg::ERR_BAD_HEADER_TEXT;
                end
                else
                begin
                    hmax_next  = acc_reg;
                    acc_next   = '0;
                    phase_next = PH_N_FIRST;
                end
            end
            PH_N_DIGITS, PH_TRAIL:
            begin
                if (phase_reg == PH_N_DIGITS && !eof_reg && is_digit)
                begin
                    if (acc_ovf)
                    begin
                        fail = 1'b1; fail_code = ctlp_pkg::ERR_HEADER_NUM_OVF;
                    end
                    else
                        acc_next = acc_sum[ctlp_pkg::ValueWidth-1:0];
                end
                else
                begin
                    // first non-digit closes the clause count, then trailing blanks
                    if (phase_reg == PH_N_DIGITS)
                    begin
                        hcl_next   = acc_reg;
                        acc_next   = '0;
                        phase_next = PH_TRAIL;
                    end
                    if (eof_reg)
                    begin
                        fail = 1'b1; fail_code = ctlp_pkg::ERR_NO_HEADER_NEWLINE;
                    end
                    else if (byte_reg == ctlp_pkg::CH_SPACE || byte_reg == ctlp_pkg::CH_TAB)
                        phase_next = PH_TRAIL;
                    else if (byte_reg == ctlp_pkg::CH_CR)
                        phase_next = PH_CR;
                    else if (byte_reg == ctlp_pkg::CH_LF)
                        header_ok = 1'b1;
                    else
                    begin
                        fail = 1'b1; fail_code = ctlp_pkg::ERR_NO_HEADER_NEWLINE;
                    end
                end
            end
            PH_CR:
            begin
                if (eof_reg || byte_reg != ctlp_pkg::CH_LF)
                begin
                    fail = 1'b1; fail_code = ctlp_pkg::ERR_NO_HEADER_NEWLINE;
                end
                else
                    header_ok = 1'b1;
            end
            PH_BODY:
            begin
                if (eof_reg)
                begin
                    if (open_reg)
                    begin
                        fail = 1'b1; fail_code = ctlp_pkg::ERR_MISSING_ZERO;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                        has_result = 1'b1;
                        kind_next  = ctlp_pkg::KIND_END;
                    end
                end
                else if (byte_reg == ctlp_pkg::CH_C)
                    phase_next = PH_BCOMMENT;
                else if (is_blank)
                    phase_next = PH_BODY;
                else if (byte_reg == ctlp_pkg::CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_MINUS;
                end
                else if (!is_digit)
                begin
                    fail = 1'b1; fail_code = ctlp_pkg::ERR_EXPECT_DIGIT_MINUS;
                end
                else
                begin
                    neg_next   = 1'b0;
                    acc_next   = {{(ctlp_pkg::ValueWidth-4){1'b0}}, digit};
                    phase_next = PH_LIT;
                end
            end
            PH_BCOMMENT:
            begin
                if (eof_reg)
                begin
                    fail = 1'b1; fail_code = ctlp_pkg::ERR_EOF_COMMENT;
                end
                else if (byte_reg == ctlp_pkg::CH_LF)
                    phase_next = PH_BODY;
            end
            PH_MINUS:
            begin
                if (eof_reg || !is_digit || byte_reg == ctlp_pkg::CH_ZERO)
                begin
                    fail = 1'b1; fail_code = ctlp_pkg::ERR_BAD_DIGIT_MINUS;
                end
                else
                begin
                    acc_next   = {{(ctlp_pkg::ValueWidth-4){1'b0}}, digit};
                    phase_next = PH_LIT;
                end
            end
            PH_LIT:
            begin
                if (eof_reg)
                begin
                    fail = 1'b1; fail_code = ctlp_pkg::ERR_BAD_DELIMITER;
                end
                else if (is_digit)
                begin
                    if (acc_ovf)
                    begin
                        fail = 1'b1; fail_code = ctlp_pkg::ERR_LITERAL_OVF;
                    end
                    else
                        acc_next = acc_sum[ctlp_pkg::ValueWidth-1:0];
                end
                else if (byte_reg == ctlp_pkg::CH_C)
                    phase_next = PH_LCOMMENT;   // comment is the delimiter
                else if (!is_blank)
                begin
                    fail = 1'b1; fail_code = ctlp_pkg::ERR_BAD_DELIMITER;
                end
                else
                begin
                    phase_next = PH_BODY;
                    emit       = 1'b1;
                end
            end
            PH_LCOMMENT:
            begin
                if (eof_reg)
                begin
                    fail = 1'b1; fail_code = ctlp_pkg::ERR_EOF_COMMENT;
                end
                else if (byte_reg == ctlp_pkg::CH_LF)
                begin
                    phase_next = PH_BODY;
                    emit       = 1'b1;
                end
            end
            PH_DONE, PH_STOP:
            begin
                phase_next = phase_reg;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        if (header_ok)
        begin
            phase_next = PH_BODY;
            has_result = 1'b1;
            kind_next  = ctlp_pkg::KIND_HEADER;
        end

        if (emit)
        begin
            if (acc_reg > hmax_reg)
            begin
                fail = 1'b1; fail_code = ctlp_pkg::ERR_EXCEEDS_MAX_VAR;
            end
            else
            begin
                has_result = 1'b1;
                kind_next  = ctlp_pkg::KIND_LITERAL;
                lit_next   = neg_reg ? (32'd0 - {1'b0, acc_reg}) : {1'b0, acc_reg};
                open_next  = (acc_reg != '0);
                acc_next   = '0;
                neg_next   = 1'b0;
            end
        end

        if (fail)
        begin
            phase_next = PH_STOP;
            has_result = 1'b1;
            kind_next  = ctlp_pkg::KIND_ERROR;
            lit_next   = '0;
            code_next  = fail_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_START;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            hmax_reg      <= '0;
            hcl_reg       <= '0;
            open_reg      <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg && has_result;
            if (fire)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                hmax_reg  <= hmax_next;
                hcl_reg   <= hcl_next;
                open_reg  <= open_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= byte_value;
            eof_reg  <= end_of_input;
        end
        if (fire && has_result)
        begin
            kind_reg <= kind_next;
            lit_reg  <= lit_next;
            max_reg  <= hmax_next;
            cl_reg   <= hcl_next;
            code_reg <= code_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign literal      = lit_reg;
    assign max_variable = max_reg;
    assign clause_count = cl_reg;
    assign error_code   = code_reg;

`ifndef NO_ASSERTIONS
    // an error or a clean end is the last word ever produced
    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall
         && (result_kind == ctlp_pkg::KIND_ERROR || result_kind == ctlp_pkg::KIND_END))
        |=> !out_valid)
        else $error("word produced after error or end");

    // a literal's magnitude never exceeds the header maximum variable
    a_lit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == ctlp_pkg::KIND_LITERAL)
        |-> ((literal[31] ? (32'd0 - literal) : literal) <= {1'b0, max_variable}))
        else $error("literal above maximum variable");

    // only error words carry a nonzero error code; header and end words carry a zero literal
    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind != ctlp_pkg::KIND_ERROR)
        |-> (error_code == ctlp_pkg::ERR_EOF_HEADER_COMMENT && (literal == 32'sd0
             || result_kind == ctlp_pkg::KIND_LITERAL)))
        else $error("stray code or literal on non-error word");
`endif

endmodule
